FILE: rtl/core/prime_factorization_trial_division_assert.svh
// assertion macros shared by the checker
`ifndef PRIME_FACTORIZATION_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_FACTORIZATION_TRIAL_DIVISION_ASSERT_SVH

// same-cycle implication
`define PFTD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pftd assertion failed");

// next-cycle implication
`define PFTD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pftd assertion failed");

`endif

FILE: rtl/core/pftd_pkg.sv
package pftd_pkg;

	localparam int WORD_BITS = 32;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef logic [3:0] pc_t;
	typedef logic [2:0] cond_t;
	typedef logic [2:0] act_t;

	localparam cond_t COND_NONE      = 3'd0;
	localparam cond_t COND_ALWAYS    = 3'd1;
	localparam cond_t COND_START_LOW = 3'd2;
	localparam cond_t COND_REST_LE1  = 3'd3;
	localparam cond_t COND_DIV_BUSY  = 3'd4;
	localparam cond_t COND_D_GT_Q    = 3'd5;
	localparam cond_t COND_REM_NZ    = 3'd6;

	localparam act_t ACT_NONE      = 3'd0;
	localparam act_t ACT_LOAD      = 3'd1;
	localparam act_t ACT_DIV_GO    = 3'd2;
	localparam act_t ACT_EMIT_D    = 3'd3;
	localparam act_t ACT_EMIT_REST = 3'd4;
	localparam act_t ACT_EMIT_NONE = 3'd5;
	localparam act_t ACT_NEXT_D    = 3'd6;

	localparam pc_t PC_IDLE  = 4'd0;
	localparam pc_t PC_CHK   = 4'd1;
	localparam pc_t PC_DIV   = 4'd2;
	localparam pc_t PC_WAIT  = 4'd3;
	localparam pc_t PC_TEST  = 4'd4;
	localparam pc_t PC_REM   = 4'd5;
	localparam pc_t PC_EMIT  = 4'd6;
	localparam pc_t PC_NEXT  = 4'd7;
	localparam pc_t PC_FINAL = 4'd8;
	localparam pc_t PC_LASTP = 4'd9;
	localparam pc_t PC_EMPTY = 4'd10;

	typedef struct packed {
		cond_t cond;
		pc_t   target;
		act_t  act;
	} ctrl_t;

	// microprogram
	function automatic ctrl_t prog_word(input pc_t pc);
		ctrl_t w;
		w = '{cond: COND_ALWAYS, target: PC_IDLE, act: ACT_NONE};
		unique case (pc)
			PC_IDLE:  w = '{cond: COND_START_LOW, target: PC_IDLE,  act: ACT_LOAD};
			PC_CHK:   w = '{cond: COND_REST_LE1,  target: PC_EMPTY, act: ACT_NONE};
			PC_DIV:   w = '{cond: COND_NONE,      target: PC_IDLE,  act: ACT_DIV_GO};
			PC_WAIT:  w = '{cond: COND_DIV_BUSY,  target: PC_WAIT,  act: ACT_NONE};
			PC_TEST:  w = '{cond: COND_D_GT_Q,    target: PC_FINAL, act: ACT_NONE};
			PC_REM:   w = '{cond: COND_REM_NZ,    target: PC_NEXT,  act: ACT_NONE};
			PC_EMIT:  w = '{cond: COND_ALWAYS,    target: PC_DIV,   act: ACT_EMIT_D};
			PC_NEXT:  w = '{cond: COND_ALWAYS,    target: PC_DIV,   act: ACT_NEXT_D};
			PC_FINAL: w = '{cond: COND_REST_LE1,  target: PC_IDLE,  act: ACT_NONE};
			PC_LASTP: w = '{cond: COND_ALWAYS,    target: PC_IDLE,  act: ACT_EMIT_REST};
			PC_EMPTY: w = '{cond: COND_ALWAYS,    target: PC_IDLE,  act: ACT_EMIT_NONE};
			default:  w = '{cond: COND_ALWAYS,    target: PC_IDLE,  act: ACT_NONE};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/pftd_div.sv
module pftd_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, den};
		fits  = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/prime_factorization_trial_division.sv
// Prime factorization by trial division.
// Command port: value is taken at a rising edge with start high and busy low;
// busy then stays high until every factor of that value has been sent.
// Result port: each factor beat is shown for one cycle with valid high, in
// ascending order, repeated by multiplicity; last marks the final beat of
// a value. Values 0 and 1 give one beat with has_factor low, factor zero.
// Bits of value above VALUE_BITS are ignored.
// Each trial candidate is one pass through the shared bit-serial divider;
// candidates are 2 and then odd numbers up to the square root of the
// unfactored part. A prime near 2^32 needs about 32768 candidates.
// The result port cannot be held off: beats are sent as they are found.
// Reset returns the sequencer to idle and drops valid; nothing else is kept
// between values.
module prime_factorization_trial_division #(
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pftd_pkg::word_t      value,
	output logic                 valid,
	output pftd_pkg::word_t      factor,
	output logic                 has_factor,
	output logic                 last
);

	import pftd_pkg::*;

	localparam int W = VALUE_BITS;
	localparam logic [W-1:0] ONE = W'(1);
	localparam logic [W-1:0] TWO = W'(2);

	pc_t               pc_q;
	ctrl_t             cw;
	logic              jump;
	logic [W-1:0]      rest_q;
	logic [W-1:0]      d_q;
	logic              div_busy;
	logic [W-1:0]      quo;
	logic [W-1:0]      rem;
	logic              rest_le1;
	logic [W+WORD_BITS-1:0] in_ext;
	logic [W+WORD_BITS-1:0] d_ext;
	logic [W+WORD_BITS-1:0] rest_ext;
	logic              valid_q;
	word_t             factor_q;
	logic              has_factor_q;
	logic              last_q;

	pftd_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cw.act == ACT_DIV_GO),
		.num    (rest_q),
		.den    (d_q),
		.busy   (div_busy),
		.quo    (quo),
		.rem    (rem)
	);

	always_comb begin
		cw       = prog_word(pc_q);
		rest_le1 = (rest_q >> 1) == '0;
		in_ext   = {{W{1'b0}}, value};
		d_ext    = {{WORD_BITS{1'b0}}, d_q};
		rest_ext = {{WORD_BITS{1'b0}}, rest_q};
		unique case (cw.cond)
			COND_NONE:      jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_START_LOW: jump = !start;
			COND_REST_LE1:  jump = rest_le1;
			COND_DIV_BUSY:  jump = div_busy;
			COND_D_GT_Q:    jump = d_q > quo;
			COND_REM_NZ:    jump = rem != '0;
			default:        jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= PC_IDLE;
			valid_q <= 1'b0;
		end else begin
			pc_q    <= jump ? cw.target : pc_q + 1'b1;
			valid_q <= (cw.act == ACT_EMIT_D) || (cw.act == ACT_EMIT_REST)
				|| (cw.act == ACT_EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.act)
			ACT_LOAD: begin
				rest_q <= in_ext[W-1:0];
				d_q    <= TWO;
			end
			ACT_EMIT_D: begin
				factor_q     <= d_ext[WORD_BITS-1:0];
				has_factor_q <= 1'b1;
				last_q       <= quo == ONE;
				rest_q       <= quo;
			end
			ACT_EMIT_REST: begin
				factor_q     <= rest_ext[WORD_BITS-1:0];
				has_factor_q <= 1'b1;
				last_q       <= 1'b1;
			end
			ACT_EMIT_NONE: begin
				factor_q     <= '0;
				has_factor_q <= 1'b0;
				last_q       <= 1'b1;
			end
			// after 2 only odd candidates
			ACT_NEXT_D: d_q <= d_q + (d_q[0] ? TWO : ONE);
			default: ;
		endcase
	end

	assign busy       = pc_q != PC_IDLE;
	assign valid      = valid_q;
	assign factor     = factor_q;
	assign has_factor = has_factor_q;
	assign last       = last_q;

endmodule

FILE: rtl/core/pftd_chk.sv
`include "prime_factorization_trial_division_assert.svh"

module pftd_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input pftd_pkg::word_t value,
	input logic            valid,
	input pftd_pkg::word_t factor,
	input logic            has_factor,
	input logic            last
);

	import pftd_pkg::*;

	`PFTD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`PFTD_ASSERT_NEXT(a_beat_spaced, valid, !valid)
	`PFTD_ASSERT_NOW(a_mid_busy, valid && !last, busy)
	`PFTD_ASSERT_NOW(a_empty_beat, valid && !has_factor, last && (factor == '0))

endmodule

bind prime_factorization_trial_division pftd_chk u_pftd_chk (.*);
